>>> sv/frc_pkg.sv
// Shared definitions for the framed command responder: item kind codes, frame
// and command byte values, reply constants and the controller/datapath structs.
// No dependencies; every other file of the block uses this package.
package frc_pkg;

   // Field widths of the request and response items.
   localparam int KIND_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int ADC_W     = 10;
   localparam int RLEN_W    = 3;
   localparam int RIDX_W    = 4;

   // Reply buffer geometry.
   localparam int REPLY_DEPTH = 8;
   localparam int REPLY_IW    = 3;

   // Default maximum frame length, counting the length byte and the checksum.
   localparam int FRAME_BYTES_DEFAULT = 16;

   // Item kinds as delivered by the bus target.
   localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ_FIRST = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ_NEXT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COLLISION  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ADDRESS    = 3'd4;

   // Framing bytes.
   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
   localparam logic [BYTE_W-1:0] FILL_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
   localparam logic [BYTE_W-1:0] ONE_BYTE    = 8'h01;

   // Command codes.
   localparam logic [BYTE_W-1:0] CMD_ECHO_A     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_ECHO_B     = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_ACK_C      = 8'h03;
   localparam logic [BYTE_W-1:0] CMD_ACK_D      = 8'h04;
   localparam logic [BYTE_W-1:0] CMD_ACK_E      = 8'h05;
   localparam logic [BYTE_W-1:0] CMD_STATUS     = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_SOFT_RESET = 8'h07;
   localparam logic [BYTE_W-1:0] CMD_ACK_H      = 8'h08;
   localparam logic [BYTE_W-1:0] CMD_ACK_I      = 8'h09;
   localparam logic [BYTE_W-1:0] CMD_POWER_KEY  = 8'h15;
   localparam logic [BYTE_W-1:0] CMD_VERSION    = 8'h16;
   localparam logic [BYTE_W-1:0] CMD_HEARTBEAT  = 8'h17;
   localparam logic [BYTE_W-1:0] CMD_ADC_READ   = 8'h3A;

   // Fixed reply contents.
   localparam logic [BYTE_W-1:0] VERSION_LEAD  = 8'h06;
   localparam logic [BYTE_W-1:0] VERSION_CHECK = 8'h1D;
   localparam logic [BYTE_W-1:0] BEAT_LEAD     = 8'h05;
   localparam logic [BYTE_W-1:0] BEAT_MARK     = 8'hAB;
   localparam logic [BYTE_W-1:0] BEAT_CHECK    = 8'hC7;
   localparam logic [BYTE_W-1:0] ADC_LEAD      = 8'h07;

   // Reply lengths.
   localparam logic [RLEN_W-1:0] RLEN_NONE    = 3'd0;
   localparam logic [RLEN_W-1:0] RLEN_PAIR    = 3'd2;
   localparam logic [RLEN_W-1:0] RLEN_BEAT    = 3'd5;
   localparam logic [RLEN_W-1:0] RLEN_VERSION = 3'd6;
   localparam logic [RLEN_W-1:0] RLEN_ADC     = 3'd7;

   localparam logic [RIDX_W-1:0] RIDX_TOP = 4'd15;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;      // apply the item just accepted
      logic answer;    // evaluate the completed frame
      logic finish;    // capture read data, apply a pending soft reset
      logic load_out;  // load the response register
   } frc_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_done;  // the last item completed a frame
   } frc_status_type;

endpackage

>>> sv/frc_if.sv
// Valid/ready channel interfaces for the framed command responder: one for
// request items and one for response items. Depends on frc_pkg for widths.
interface frc_req_if;
   logic                         valid;
   logic                         ready;
   logic [frc_pkg::KIND_W-1:0]   kind;
   logic [frc_pkg::BYTE_W-1:0]   data_byte;
   logic [frc_pkg::ADC_W-1:0]    adc_sample;

   modport source (output valid, kind, data_byte, adc_sample, input ready);
   modport sink   (input valid, kind, data_byte, adc_sample, output ready);
endinterface

interface frc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [frc_pkg::BYTE_W-1:0]   read_data;
   logic                         packet_done;
   logic [frc_pkg::RLEN_W-1:0]   response_length;
   logic                         power_enable;

   modport source (output valid, read_data, packet_done, response_length, power_enable,
                   input ready);
   modport sink   (input valid, read_data, packet_done, response_length, power_enable,
                   output ready);
endinterface

>>> sv/framed_command_responder_unit.sv
// Top level of the framed command responder: ties the controller and the
// datapath to the request and response channels. Depends on frc_pkg, frc_if,
// frc_ctrl and frc_datapath.
//
// This block sits behind an I2C target and turns the bytes written by the bus
// master into framed commands: 0x55, 0xAA, a length byte (2 up to FRAME_BYTES,
// counting itself), a command, payload bytes and an additive 8-bit checksum.
// Each request item reports one bus event (data write, first read, next read,
// write collision or address write) and yields exactly one response item with
// the read byte (0xFF past the end of the reply, 0 for non-read events), a
// frame-complete flag, the current reply length and the power key output.
// The checksum is accumulated as the bytes arrive, so a frame is judged in the
// cycle after its last byte; a bad checksum leaves no reply. A soft reset
// command clears the framing and reply state but not the power key once its
// reply has been read. An item passes through four steps: the transfer that
// applies the bus event, the command decode and reply build, the capture of the
// read byte with any pending soft reset, and the load of the response register.
// The controller handles one item at a time, so this sequence sets the rate; a
// response that waits to be taken adds its wait only when the next item reaches
// the output step, since the response register stays apart from the input side.
// No clearing pass is needed after reset: the frame registers and the reply
// buffer are always written before they are read.
module framed_command_responder_unit #(
   parameter int FRAME_BYTES = frc_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   frc_req_if.sink   req_channel,
   frc_rsp_if.source rsp_channel
);
   import frc_pkg::*;

   // Command and status groups between the controller and the datapath.
   frc_ctrl_type   ctrl;
   frc_status_type status;

   // The controller owns the handshakes; the datapath owns all payload.
   frc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // The datapath samples the request payload during the request transfer and
   // holds the response payload steady while the response waits.
   frc_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .req_kind            (req_channel.kind),
      .req_data_byte       (req_channel.data_byte),
      .req_adc_sample      (req_channel.adc_sample),
      .rsp_read_data       (rsp_channel.read_data),
      .rsp_packet_done     (rsp_channel.packet_done),
      .rsp_response_length (rsp_channel.response_length),
      .rsp_power_enable    (rsp_channel.power_enable)
   );

endmodule

>>> sv/frc_ctrl.sv
// Controller of the framed command responder: sequences each item through its
// step, answer, finish and output cycles. Depends on frc_pkg.
module frc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  frc_pkg::frc_status_type status,
   output frc_pkg::frc_ctrl_type   ctrl
);
   import frc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ANSWER, ST_FINISH, ST_OUTPUT} state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      ctrl.step     = ready_ff && req_valid;
      ctrl.answer   = (state_ff == ST_ANSWER) && status.frame_done;
      ctrl.finish   = (state_ff == ST_FINISH);
      ctrl.load_out = (state_ff == ST_OUTPUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         // A new response replaces the one taken in the same cycle.
         if ((state_ff == ST_OUTPUT) && out_free) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_ANSWER;
               end
            end
            ST_ANSWER: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               state_ff <= ST_OUTPUT;
            end
            ST_OUTPUT: begin
               if (out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

>>> sv/frc_datapath.sv
// Datapath of the framed command responder: framing registers, running frame
// checksum, reply buffer, read pointer and response register. Depends on frc_pkg.
module frc_datapath #(
   parameter int FRAME_BYTES = frc_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  frc_pkg::frc_ctrl_type       ctrl,
   output frc_pkg::frc_status_type     status,
   input  logic [frc_pkg::KIND_W-1:0]  req_kind,
   input  logic [frc_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [frc_pkg::ADC_W-1:0]   req_adc_sample,
   output logic [frc_pkg::BYTE_W-1:0]  rsp_read_data,
   output logic                        rsp_packet_done,
   output logic [frc_pkg::RLEN_W-1:0]  rsp_response_length,
   output logic                        rsp_power_enable
);
   import frc_pkg::*;

   localparam int                CW      = $clog2(FRAME_BYTES + 1);
   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(FRAME_BYTES);
   localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

   typedef enum logic [1:0] {PH_IDLE, PH_PREAMBLE, PH_LENGTH, PH_DATA} phase_type;

   // Control state.
   phase_type          phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [RLEN_W-1:0]  rlen_ff, rlen_in;
   logic [RIDX_W-1:0]  idx_ff, idx_in;
   logic               pending_ff, pending_in;
   logic               key_ff, key_in;
   logic               done_ff, done_in;

   // Frame accumulation and item registers.
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic               nz_ff, nz_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  arg_ff, arg_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [ADC_W-1:0]   adc_ff, adc_in;
   logic [BYTE_W-1:0]  rd_ff, rd_in;

   logic [BYTE_W-1:0]  reply_ff [REPLY_DEPTH];
   logic [BYTE_W-1:0]  reply_in [REPLY_DEPTH];

   // Response register.
   logic [BYTE_W-1:0]  out_data_ff;
   logic               out_done_ff;
   logic [RLEN_W-1:0]  out_rlen_ff;
   logic               out_key_ff;

   // Frame position and reply builder signals.
   logic [CW:0]        next_count;
   logic               last_byte;
   logic               len_ok;
   logic               payload_zero;
   logic               len_ge3;
   logic [8:0]         adc_sum;
   logic [BYTE_W-1:0]  new_reply [REPLY_DEPTH];
   logic [RLEN_W-1:0]  new_rlen;
   logic               new_pending;
   logic               key_write;
   logic               key_value;
   logic [BYTE_W-1:0]  read_byte;
   logic               is_read;

   assign next_count   = {1'b0, count_ff} + (CW+1)'(1);
   assign last_byte    = next_count >= {1'b0, len_ff};
   assign len_ok       = (req_data_byte >= MIN_LEN) && (req_data_byte <= MAX_LEN);
   assign payload_zero = !nz_ff;
   assign len_ge3      = len_ff >= CW'(3);
   assign adc_sum      = 9'(ADC_LEAD) + 9'(CMD_ADC_READ) + 9'(ONE_BYTE)
                       + {7'b0, adc_ff[9:8]} + {1'b0, adc_ff[7:0]};
   assign read_byte    = ({1'b0, rlen_ff} > idx_ff) ? reply_ff[idx_ff[REPLY_IW-1:0]]
                                                     : FILL_BYTE;
   assign is_read      = (kind_ff == KIND_READ_FIRST) || (kind_ff == KIND_READ_NEXT);

   assign status.frame_done = done_ff;

   // Reply for the command of a frame whose checksum was good.
   always_comb begin
      for (int i = 0; i < REPLY_DEPTH; i++) begin
         new_reply[i] = ZERO_BYTE;
      end
      new_rlen    = RLEN_NONE;
      new_pending = 1'b0;
      key_write   = 1'b0;
      key_value   = 1'b0;
      unique case (cmd_ff) inside
         CMD_ECHO_A, CMD_ECHO_B: begin
            new_reply[0] = cmd_ff;
            new_rlen     = RLEN_PAIR;
         end
         CMD_ACK_C, CMD_ACK_D, CMD_ACK_E, CMD_ACK_H, CMD_ACK_I: begin
            new_reply[0] = payload_zero ? cmd_ff : FILL_BYTE;
            new_reply[1] = payload_zero ? ZERO_BYTE : FILL_BYTE;
            new_rlen     = RLEN_PAIR;
         end
         CMD_STATUS, CMD_SOFT_RESET: begin
            new_reply[0] = payload_zero ? cmd_ff : FILL_BYTE;
            new_reply[1] = payload_zero ? ONE_BYTE : FILL_BYTE;
            new_rlen     = RLEN_PAIR;
            new_pending  = payload_zero && (cmd_ff == CMD_SOFT_RESET);
         end
         CMD_POWER_KEY: begin
            if (len_ge3) begin
               key_write    = 1'b1;
               key_value    = (arg_ff == ONE_BYTE);
               new_reply[0] = CMD_POWER_KEY;
               new_reply[1] = ONE_BYTE;
               new_rlen     = RLEN_PAIR;
            end
         end
         CMD_VERSION: begin
            new_reply[0] = VERSION_LEAD;
            new_reply[1] = CMD_VERSION;
            new_reply[2] = ONE_BYTE;
            new_reply[5] = VERSION_CHECK;
            new_rlen     = RLEN_VERSION;
         end
         CMD_HEARTBEAT: begin
            if (payload_zero) begin
               new_reply[0] = BEAT_LEAD;
               new_reply[1] = CMD_HEARTBEAT;
               new_reply[2] = BEAT_MARK;
               new_reply[4] = BEAT_CHECK;
               new_rlen     = RLEN_BEAT;
            end else begin
               new_reply[0] = FILL_BYTE;
               new_reply[1] = FILL_BYTE;
               new_rlen     = RLEN_PAIR;
            end
         end
         CMD_ADC_READ: begin
            if (!payload_zero) begin
               new_reply[0] = FILL_BYTE;
               new_reply[1] = FILL_BYTE;
               new_rlen     = RLEN_PAIR;
            end else if (len_ge3 && (arg_ff == ZERO_BYTE)) begin
               new_reply[0] = ADC_LEAD;
               new_reply[1] = CMD_ADC_READ;
               new_reply[2] = ONE_BYTE;
               new_reply[3] = {6'b0, adc_ff[9:8]};
               new_reply[4] = adc_ff[7:0];
               new_reply[5] = {7'b0, adc_sum[8]};
               new_reply[6] = adc_sum[7:0];
               new_rlen     = RLEN_ADC;
            end else if (len_ge3) begin
               new_reply[0] = CMD_ADC_READ;
               new_rlen     = RLEN_PAIR;
            end
         end
         default: begin
         end
      endcase
   end

   // Next-state logic for every register but the response register, one command at a time.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      rlen_in    = rlen_ff;
      idx_in     = idx_ff;
      pending_in = pending_ff;
      key_in     = key_ff;
      done_in    = done_ff;
      sum_in     = sum_ff;
      nz_in      = nz_ff;
      cmd_in     = cmd_ff;
      arg_in     = arg_ff;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      adc_in     = adc_ff;
      rd_in      = rd_ff;
      for (int i = 0; i < REPLY_DEPTH; i++) begin
         reply_in[i] = reply_ff[i];
      end

      if (ctrl.step) begin
         kind_in = req_kind;
         byte_in = req_data_byte;
         adc_in  = req_adc_sample;
         done_in = 1'b0;
         case (req_kind)
            KIND_COLLISION: begin
               phase_in = PH_IDLE;
            end
            KIND_READ_NEXT: begin
               if (idx_ff != RIDX_TOP) begin
                  idx_in = idx_ff + RIDX_W'(1);
               end
            end
            KIND_WRITE: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     if (req_data_byte == SYNC_FIRST) begin
                        phase_in = PH_PREAMBLE;
                     end
                  end
                  PH_PREAMBLE: begin
                     phase_in = (req_data_byte == SYNC_SECOND) ? PH_LENGTH : PH_IDLE;
                  end
                  PH_LENGTH: begin
                     len_in   = req_data_byte[CW-1:0];
                     count_in = CW'(1);
                     sum_in   = req_data_byte;
                     nz_in    = 1'b0;
                     phase_in = len_ok ? PH_DATA : PH_IDLE;
                  end
                  PH_DATA: begin
                     count_in = next_count[CW-1:0];
                     if (count_ff == CW'(1)) begin
                        cmd_in = req_data_byte;
                     end
                     if (count_ff == CW'(2)) begin
                        arg_in = req_data_byte;
                     end
                     if (last_byte) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        sum_in = sum_ff + req_data_byte;
                        if (count_ff >= CW'(2)) begin
                           nz_in = nz_ff || (req_data_byte != ZERO_BYTE);
                        end
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (ctrl.answer) begin
         if (sum_ff == byte_ff) begin
            rlen_in    = new_rlen;
            idx_in     = '0;
            pending_in = new_pending;
            for (int i = 0; i < REPLY_DEPTH; i++) begin
               reply_in[i] = new_reply[i];
            end
            if (key_write) begin
               key_in = key_value;
            end
         end else begin
            rlen_in = RLEN_NONE;
         end
      end

      if (ctrl.finish) begin
         rd_in = is_read ? read_byte : ZERO_BYTE;
         if (pending_ff && (idx_ff >= {1'b0, rlen_ff})) begin
            phase_in   = PH_IDLE;
            count_in   = '0;
            len_in     = '0;
            rlen_in    = RLEN_NONE;
            idx_in     = '0;
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         len_ff     <= '0;
         rlen_ff    <= RLEN_NONE;
         idx_ff     <= '0;
         pending_ff <= 1'b0;
         key_ff     <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         len_ff     <= len_in;
         rlen_ff    <= rlen_in;
         idx_ff     <= idx_in;
         pending_ff <= pending_in;
         key_ff     <= key_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      nz_ff   <= nz_in;
      cmd_ff  <= cmd_in;
      arg_ff  <= arg_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      adc_ff  <= adc_in;
      rd_ff   <= rd_in;
      for (int i = 0; i < REPLY_DEPTH; i++) begin
         reply_ff[i] <= reply_in[i];
      end
      if (ctrl.load_out) begin
         out_data_ff <= rd_ff;
         out_done_ff <= done_ff;
         out_rlen_ff <= rlen_ff;
         out_key_ff  <= key_ff;
      end
   end

   assign rsp_read_data       = out_data_ff;
   assign rsp_packet_done     = out_done_ff;
   assign rsp_response_length = out_rlen_ff;
   assign rsp_power_enable    = out_key_ff;

endmodule

>>> sim/frc_checker.sv
`timescale 1ns / 100ps
// Response checker for framed_command_responder_unit: watches both channels,
// predicts every response from its own copy of the framing and reply state and
// compares field by field. Depends on frc_pkg.
module frc_checker
   import frc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [ADC_W-1:0]  req_adc_sample,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_read_data,
   input  logic              rsp_packet_done,
   input  logic [RLEN_W-1:0] rsp_response_length,
   input  logic              rsp_power_enable,
   output int                fail_count,
   output int                outstanding,
   output int                frames_closed,
   output int                reply_bytes
);

   localparam int FRAME_MAX = FRAME_BYTES_DEFAULT;

   typedef enum logic [1:0] {PH_IDLE, PH_SYNC, PH_LENGTH, PH_BODY} framing_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              packet_done;
      logic [RLEN_W-1:0] response_length;
      logic              power_enable;
   } resp_fields_type;

   framing_type       phase;
   logic [BYTE_W-1:0] frame_buf [FRAME_MAX];
   int unsigned       frame_fill;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] reply_buf [REPLY_DEPTH];
   logic [RLEN_W-1:0] reply_len;
   logic [RIDX_W-1:0] reply_pos;
   logic              reset_armed;
   logic              key_on;
   resp_fields_type   expected_q [$];
   int                errors = 0;
   int                closed = 0;
   int                served = 0;

   // Everything but the power key; used at reset and by the soft reset command.
   function automatic void clear_framing_and_reply();
      phase       = PH_IDLE;
      frame_fill  = 0;
      frame_len   = '0;
      reply_len   = RLEN_NONE;
      reply_pos   = '0;
      reset_armed = 1'b0;
      for (int i = 0; i < FRAME_MAX; i++) frame_buf[i] = '0;
      for (int i = 0; i < REPLY_DEPTH; i++) reply_buf[i] = '0;
   endfunction

   function automatic logic [BYTE_W-1:0] reply_at();
      if (reply_pos < reply_len) begin
         served++;
         return reply_buf[reply_pos[2:0]];
      end
      return FILL_BYTE;
   endfunction

   function automatic void load_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
      reply_buf[0] = a;
      reply_buf[1] = b;
      reply_len    = RLEN_PAIR;
   endfunction

   // Applies one bus event to the state and returns the response it causes.
   function automatic resp_fields_type predict_response(input logic [KIND_W-1:0] kind,
                                                        input logic [BYTE_W-1:0] b,
                                                        input logic [ADC_W-1:0]  adc);
      resp_fields_type r;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] cmd;
      logic              pay_ok;
      logic [15:0]       adc_sum;
      int                n;
      r = '0;
      case (kind)
         KIND_COLLISION: phase = PH_IDLE;
         KIND_READ_FIRST: r.read_data = reply_at();
         KIND_READ_NEXT: begin
            if (reply_pos != RIDX_TOP) reply_pos = reply_pos + 1'b1;
            r.read_data = reply_at();
         end
         KIND_WRITE: begin
            case (phase)
               PH_IDLE: if (b == SYNC_FIRST) phase = PH_SYNC;
               PH_SYNC: begin
                  if (b == SYNC_SECOND) begin
                     phase      = PH_LENGTH;
                     frame_fill = 0;
                     frame_len  = '0;
                  end else begin
                     phase = PH_IDLE;
                  end
               end
               PH_LENGTH: begin
                  frame_len    = b;
                  frame_buf[0] = b;
                  frame_fill   = 1;
                  phase = (b < 2 || b > FRAME_MAX) ? PH_IDLE : PH_BODY;
               end
               default: begin
                  if (frame_fill < FRAME_MAX) begin
                     frame_buf[frame_fill] = b;
                     frame_fill++;
                  end
                  if (frame_fill >= frame_len) begin
                     phase         = PH_IDLE;
                     r.packet_done = 1'b1;
                     n   = frame_len;
                     sum = '0;
                     for (int i = 0; i < n - 1; i++) sum += frame_buf[i];
                     if (sum != frame_buf[n-1]) begin
                        // Bad checksum drops the reply but keeps the read position.
                        reply_len = RLEN_NONE;
                     end else begin
                        cmd    = frame_buf[1];
                        pay_ok = 1'b1;
                        for (int i = 2; i < n - 1; i++)
                           if (frame_buf[i] != ZERO_BYTE) pay_ok = 1'b0;
                        reset_armed = 1'b0;
                        reply_len   = RLEN_NONE;
                        case (cmd)
                           CMD_ECHO_A, CMD_ECHO_B: load_pair(cmd, ZERO_BYTE);
                           CMD_ACK_C, CMD_ACK_D, CMD_ACK_E, CMD_ACK_H, CMD_ACK_I: begin
                              if (pay_ok) load_pair(cmd, ZERO_BYTE);
                              else load_pair(FILL_BYTE, FILL_BYTE);
                           end
                           CMD_STATUS: begin
                              if (pay_ok) load_pair(CMD_STATUS, ONE_BYTE);
                              else load_pair(FILL_BYTE, FILL_BYTE);
                           end
                           CMD_SOFT_RESET: begin
                              if (pay_ok) begin
                                 load_pair(CMD_SOFT_RESET, ONE_BYTE);
                                 reset_armed = 1'b1;
                              end else begin
                                 load_pair(FILL_BYTE, FILL_BYTE);
                              end
                           end
                           CMD_POWER_KEY: begin
                              if (n >= 3) begin
                                 key_on = (frame_buf[2] == ONE_BYTE);
                                 load_pair(CMD_POWER_KEY, ONE_BYTE);
                              end
                           end
                           CMD_VERSION: begin
                              reply_buf[0] = VERSION_LEAD;
                              reply_buf[1] = CMD_VERSION;
                              reply_buf[2] = ONE_BYTE;
                              reply_buf[3] = ZERO_BYTE;
                              reply_buf[4] = ZERO_BYTE;
                              reply_buf[5] = VERSION_CHECK;
                              reply_len    = RLEN_VERSION;
                           end
                           CMD_HEARTBEAT: begin
                              if (pay_ok) begin
                                 reply_buf[0] = BEAT_LEAD;
                                 reply_buf[1] = CMD_HEARTBEAT;
                                 reply_buf[2] = BEAT_MARK;
                                 reply_buf[3] = ZERO_BYTE;
                                 reply_buf[4] = BEAT_CHECK;
                                 reply_len    = RLEN_BEAT;
                              end else begin
                                 load_pair(FILL_BYTE, FILL_BYTE);
                              end
                           end
                           CMD_ADC_READ: begin
                              if (!pay_ok) begin
                                 load_pair(FILL_BYTE, FILL_BYTE);
                              end else if (n >= 3) begin
                                 if (frame_buf[2] == ZERO_BYTE) begin
                                    reply_buf[0] = ADC_LEAD;
                                    reply_buf[1] = CMD_ADC_READ;
                                    reply_buf[2] = ONE_BYTE;
                                    reply_buf[3] = {6'b0, adc[9:8]};
                                    reply_buf[4] = adc[7:0];
                                    adc_sum = 16'(ADC_LEAD) + 16'(CMD_ADC_READ)
                                            + 16'(ONE_BYTE)
                                            + 16'(adc[9:8]) + 16'(adc[7:0]);
                                    reply_buf[5] = adc_sum[15:8];
                                    reply_buf[6] = adc_sum[7:0];
                                    reply_len    = RLEN_ADC;
                                 end else begin
                                    load_pair(CMD_ADC_READ, ZERO_BYTE);
                                 end
                              end
                           end
                           default: ;
                        endcase
                        reply_pos = '0;
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
      if (reset_armed && reply_pos >= reply_len) clear_framing_and_reply();
      r.response_length = reply_len;
      r.power_enable    = key_on;
      return r;
   endfunction

   always @(posedge clock) begin
      resp_fields_type seen;
      resp_fields_type want;
      if (reset) begin
         clear_framing_and_reply();
         key_on = 1'b0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(predict_response(req_kind, req_data_byte, req_adc_sample));
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_read_data, rsp_packet_done, rsp_response_length, rsp_power_enable};
            if (seen.packet_done === 1'b1) closed++;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t frc_checker: unexpected rd=%h done=%b len=%0d pwr=%b",
                           $realtime, seen.read_data, seen.packet_done,
                           seen.response_length, seen.power_enable);
            end else begin
               want = expected_q.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t frc_checker: expected rd=%h done=%b len=%0d pwr=%b",
                              $realtime, want.read_data, want.packet_done,
                              want.response_length, want.power_enable);
                     $display("%0t frc_checker: actual   rd=%h done=%b len=%0d pwr=%b",
                              $realtime, seen.read_data, seen.packet_done,
                              seen.response_length, seen.power_enable);
                  end
               end
            end
         end
      end
      fail_count    <= errors;
      outstanding   <= expected_q.size();
      frames_closed <= closed;
      reply_bytes   <= served;
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for framed_command_responder_unit: clock, reset, bus event
// stimulus and response-side backpressure; frc_checker does the comparison.
// Depends on frc_pkg, frc_if, the block's RTL and sim/frc_checker.sv.
module tb_top;
   import frc_pkg::*;

   // Command codes the block leaves unanswered, and the highest unused kind.
   localparam logic [BYTE_W-1:0] CMD_BITBANG_W = 8'h3B;
   localparam logic [BYTE_W-1:0] CMD_BITBANG_R = 8'h3C;
   localparam logic [KIND_W-1:0] KIND_SPARE_TOP = 3'd7;

   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 200;
   localparam int GAP_PCT      = 37;

   logic clock;
   logic reset;
   bit   gaps_on  = 1'b0;
   bit   hold_req = 1'b0;
   int   items_sent = 0;
   int   fail_count;
   int   outstanding;
   int   frames_closed;
   int   reply_bytes;

   frc_req_if req_ch();
   frc_rsp_if rsp_ch();

   framed_command_responder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   frc_checker chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_kind            (req_ch.kind),
      .req_data_byte       (req_ch.data_byte),
      .req_adc_sample      (req_ch.adc_sample),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_read_data       (rsp_ch.read_data),
      .rsp_packet_done     (rsp_ch.packet_done),
      .rsp_response_length (rsp_ch.response_length),
      .rsp_power_enable    (rsp_ch.power_enable),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .frames_closed       (frames_closed),
      .reply_bytes         (reply_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The run is bounded well above the slowest legal run: about a thousand
   // items plus random stalls and the hold-off stay far below this.
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Response side. While gaps are on, ready is dropped at random; when the stimulus
   // asks for a hold-off, ready is held low for HOLD_CYCLES so that the
   // block's response register fills and the request side backs up.
   initial begin : rsp_side
      int held;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
      end
   end

   // Offers one bus event and returns at the edge where its transfer happens.
   // Inputs are only ever changed by one nonblocking assignment per edge, and
   // ready is read in the active region right after the edge, so it still holds
   // the value the block presented for that edge.
   task automatic put_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                           input logic [ADC_W-1:0] adc);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.data_byte  <= data;
      req_ch.adc_sample <= adc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // Address writes and the spare kinds do nothing, so they are not counted.
      if (kind <= KIND_COLLISION) items_sent++;
   endtask

   // Converter readings lean toward both ends of the range.
   function automatic logic [ADC_W-1:0] pick_adc();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return ADC_W'($urandom);
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_command();
      case ($urandom_range(16))
         0:  return CMD_ECHO_A;
         1:  return CMD_ECHO_B;
         2:  return CMD_ACK_C;
         3:  return CMD_ACK_D;
         4:  return CMD_ACK_E;
         5:  return CMD_STATUS;
         6:  return CMD_SOFT_RESET;
         7:  return CMD_ACK_H;
         8:  return CMD_ACK_I;
         9:  return CMD_POWER_KEY;
         10: return CMD_VERSION;
         11: return CMD_HEARTBEAT;
         12: return CMD_ADC_READ;
         13: return CMD_BITBANG_W;
         14: return CMD_BITBANG_R;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   task automatic write_byte(input logic [BYTE_W-1:0] b);
      put_item(KIND_WRITE, b, pick_adc());
   endtask

   // Sends sync bytes, the length byte and, for a legal length, the command,
   // payload and checksum. A length of two means the checksum doubles as the
   // command byte. A bad checksum has exactly one bit flipped.
   task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
                             input bit zero_body, input bit good_sum);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] body;
      sum = len;
      write_byte(SYNC_FIRST);
      write_byte(SYNC_SECOND);
      write_byte(len);
      if (len < 2 || len > FRAME_BYTES_DEFAULT) return;
      for (int i = 1; i < len - 1; i++) begin
         if (i == 1)
            body = cmd;
         else if (zero_body)
            body = ZERO_BYTE;
         else if (i == 2 && $urandom_range(1))
            body = $urandom_range(1) ? ONE_BYTE : ZERO_BYTE;
         else
            body = BYTE_W'($urandom);
         sum += body;
         write_byte(body);
      end
      write_byte(good_sum ? sum : sum ^ (8'd1 << $urandom_range(7)));
   endtask

   // A first read followed by a number of next reads.
   task automatic read_reply(input int nexts);
      put_item(KIND_READ_FIRST, BYTE_W'($urandom), pick_adc());
      repeat (nexts) put_item(KIND_READ_NEXT, BYTE_W'($urandom), pick_adc());
   endtask

   initial begin : stimulus
      int          base;
      int          progress;
      int          pick;
      bit          held;
      logic [BYTE_W-1:0] len;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.kind          <= KIND_WRITE;
      req_ch.data_byte     <= '0;
      req_ch.adc_sample    <= '0;
      held = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, without gaps. Ignored kinds first, with the data and
      // converter fields at both extremes.
      put_item(KIND_ADDRESS, 8'hFF, '1);
      put_item(KIND_SPARE_TOP, 8'h00, '0);
      // Length-two frame: the command byte is the checksum, so it answers as an echo.
      send_frame(8'd2, CMD_ECHO_B, 1'b1, 1'b1);
      // Reads walk past the end of the reply into fill bytes.
      read_reply(2);
      // Broken preamble, then an overlong length byte.
      write_byte(SYNC_FIRST);
      write_byte(ZERO_BYTE);
      send_frame(8'd17, CMD_ECHO_A, 1'b1, 1'b1);
      // Collision right after the sync bytes drops the frame under way.
      write_byte(SYNC_FIRST);
      write_byte(SYNC_SECOND);
      put_item(KIND_COLLISION, 8'hFF, pick_adc());
      // Bad checksum clears the reply length.
      send_frame(8'd2, ZERO_BYTE, 1'b1, 1'b0);
      // Soft reset takes effect once its two-byte reply has been read out.
      send_frame(8'd3, CMD_SOFT_RESET, 1'b1, 1'b1);
      read_reply(2);

      // Random part. Mostly well-formed frames with random commands and sizes,
      // followed by reads; the rest is read bursts, broken frames and noise.
      gaps_on = 1'b1;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         progress = items_sent - base;
         gaps_on  = !(progress >= 500 && progress < 650);

         if (!held && progress >= 300) begin
            // Long output hold-off while requests keep coming back to back,
            // then a pause until every response has drained.
            held     = 1'b1;
            hold_req = 1'b1;
            gaps_on  = 1'b0;
            repeat (6) send_frame(8'($urandom_range(2, 4)), pick_command(), 1'b1, 1'b1);
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            gaps_on = 1'b1;
         end

         pick = $urandom_range(99);
         if (pick < 60) begin
            case ($urandom_range(19))
               0:       len = 8'($urandom_range(0, 1));
               1:       len = 8'($urandom_range(17, 255));
               2:       len = 8'(FRAME_BYTES_DEFAULT);
               3, 4:    len = 8'($urandom_range(7, 15));
               default: len = 8'($urandom_range(2, 6));
            endcase
            send_frame(len, pick_command(), $urandom_range(9) < 7, $urandom_range(9) < 8);
            if ($urandom_range(9) < 7) read_reply($urandom_range(0, 8));
         end else if (pick < 75) begin
            // Occasionally long enough to pin the read position at its top.
            read_reply(($urandom_range(3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8));
         end else if (pick < 82) begin
            write_byte(SYNC_FIRST);
            if ($urandom_range(1)) begin
               write_byte(SYNC_SECOND);
               write_byte(8'($urandom_range(2, 16)));
               put_item(KIND_COLLISION, BYTE_W'($urandom), pick_adc());
            end else begin
               write_byte(BYTE_W'($urandom));
            end
         end else begin
            put_item(KIND_W'($urandom), BYTE_W'($urandom), pick_adc());
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("summary: %0d bus events, %0d frames completed, %0d reply bytes served",
               items_sent, frames_closed, reply_bytes);
      $display("summary: all kinds, bad frames and sums, soft reset, %0d-cycle hold-off",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
